### rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// Build with NO_ASSERTIONS defined to drop every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### rtl/lpct_pkg.sv
package lpct_pkg;

  // Fixed field widths
  localparam int CAP_W   = 5;
  localparam int PAGE_W  = 32;
  localparam int COUNT_W = 32;

  // Capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Controller to datapath
  typedef struct packed {
    logic load;    // latch the incoming page
    logic lookup;  // compare all frames, pick the frame to promote
    logic commit;  // update ranks, pages, totals and the result register
  } lpct_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;  // result register empty or being drained this cycle
  } lpct_status_t;

endpackage

### rtl/lpct_in_if.sv
interface lpct_in_if;
  logic                          valid;
  logic                          ready;
  logic [lpct_pkg::PAGE_W-1:0]   page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

### rtl/lpct_out_if.sv
interface lpct_out_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [lpct_pkg::COUNT_W-1:0]  hit_total;
  logic [lpct_pkg::COUNT_W-1:0]  miss_total;

  modport source (output valid, output hit, output hit_total, output miss_total,
                  input ready);
  modport sink   (input valid, input hit, input hit_total, input miss_total,
                  output ready);
endinterface

### rtl/lpct_ctrl.sv
`include "assert_macros.svh"

module lpct_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  lpct_pkg::lpct_status_t  st,
  output lpct_pkg::lpct_cmd_t     cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_COMMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // A new beat is taken when idle, or in the same cycle the previous one commits
  always_comb begin
    in_ready   = (state_r == S_IDLE) || ((state_r == S_COMMIT) && st.out_free);
    cmd.load   = in_valid && in_ready;
    cmd.lookup = (state_r == S_LOOKUP);
    cmd.commit = (state_r == S_COMMIT) && st.out_free;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.load) state_nxt = S_LOOKUP;
      end
      S_LOOKUP: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (st.out_free) state_nxt = cmd.load ? S_LOOKUP : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ASSERT_CLK(a_lookup_then_commit, clk, rst_n,
    (state_r == S_LOOKUP) |=> (state_r == S_COMMIT), "lookup not followed by commit")
  `ASSERT_CLK(a_no_accept_in_lookup, clk, rst_n,
    (state_r == S_LOOKUP) |-> !in_ready, "beat accepted during lookup")
  `ASSERT_CLK(a_commit_after_lookup, clk, rst_n,
    cmd.commit |-> ($past(state_r) == S_LOOKUP || $past(state_r) == S_COMMIT),
    "commit without a lookup")

endmodule

### rtl/lpct_dpath.sv
`include "assert_macros.svh"

module lpct_dpath #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lpct_pkg::CAP_W-1:0]       cfg_wdata,
  input  logic [lpct_pkg::PAGE_W-1:0]      page_in,
  input  lpct_pkg::lpct_cmd_t              cmd,
  output lpct_pkg::lpct_status_t           st,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_hit,
  output logic [lpct_pkg::COUNT_W-1:0]     out_hit_total,
  output logic [lpct_pkg::COUNT_W-1:0]     out_miss_total
);

  localparam int SW = (PAGE_BITS < lpct_pkg::PAGE_W) ? PAGE_BITS : lpct_pkg::PAGE_W;
  localparam int RW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int OW = $clog2(FRAMES + 1);

  // Frame contents: one cell per frame
  logic [SW-1:0]                  pages_r [FRAMES];
  logic [RW-1:0]                  rank_r  [FRAMES];
  logic [OW-1:0]                  occ_r;
  logic [lpct_pkg::CAP_W-1:0]     cap_r;
  logic [lpct_pkg::COUNT_W-1:0]   hits_r;
  logic [lpct_pkg::COUNT_W-1:0]   misses_r;

  // Current reference and lookup results
  logic [SW-1:0]                  page_r;
  logic [FRAMES-1:0]              sel_r;
  logic [RW-1:0]                  selrank_r;
  logic                           hit_r;
  logic [OW-1:0]                  occn_r;

  logic                           out_valid_r;
  logic                           out_hit_r;

  logic [FRAMES-1:0]              match;
  logic [FRAMES-1:0]              victim;
  logic                           hit_nxt;
  logic [OW-1:0]                  eff_cap;
  logic [RW-1:0]                  victim_rank;
  logic [RW-1:0]                  hit_rank;
  logic [OW-1:0]                  occ_miss;

  // Capacity clamped to 1..FRAMES
  always_comb begin
    int ci;
    ci = int'(cap_r);
    if (ci == 0) ci = 1;
    if (ci > FRAMES) ci = FRAMES;
    eff_cap = OW'(ci);
  end

  // Parallel compare over valid frames, plus victim choice on a miss
  always_comb begin
    if (occ_r >= eff_cap) begin
      victim_rank = RW'(eff_cap - OW'(1));
      occ_miss    = eff_cap;
    end else begin
      victim_rank = RW'(occ_r);
      occ_miss    = occ_r + OW'(1);
    end
    hit_rank = '0;
    for (int i = 0; i < FRAMES; i++) begin
      match[i]  = (32'(rank_r[i]) < 32'(occ_r)) && (pages_r[i] == page_r);
      victim[i] = (rank_r[i] == victim_rank);
      hit_rank  = hit_rank | (match[i] ? rank_r[i] : '0);
    end
    hit_nxt = |match;
  end

  // Config register and reference latch
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lpct_pkg::CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) page_r <= page_in[SW-1:0];
  end

  // Lookup stage registers
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      sel_r     <= hit_nxt ? match : victim;
      selrank_r <= hit_nxt ? hit_rank : victim_rank;
      hit_r     <= hit_nxt;
      occn_r    <= hit_nxt ? occ_r : occ_miss;
    end
  end

  // Recency cells: promote the selected frame, shift younger ones down
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FRAMES; i++) rank_r[i] <= RW'(i);
      occ_r    <= '0;
      hits_r   <= '0;
      misses_r <= '0;
    end else if (cmd.commit) begin
      for (int i = 0; i < FRAMES; i++) begin
        if (sel_r[i]) begin
          rank_r[i] <= '0;
        end else if (rank_r[i] < selrank_r) begin
          rank_r[i] <= rank_r[i] + RW'(1);
        end
      end
      occ_r <= occn_r;
      if (hit_r) begin
        hits_r <= hits_r + lpct_pkg::COUNT_W'(1);
      end else begin
        misses_r <= misses_r + lpct_pkg::COUNT_W'(1);
      end
    end
  end

  // Page write into the chosen frame on a miss
  always_ff @(posedge clk) begin
    if (cmd.commit && !hit_r) begin
      for (int i = 0; i < FRAMES; i++) begin
        if (sel_r[i]) pages_r[i] <= page_r;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) out_hit_r <= hit_r;
  end

  assign st.out_free     = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_hit_total   = hits_r;
  assign out_miss_total  = misses_r;

  `ASSERT_CLK(a_sel_onehot, clk, rst_n,
    cmd.commit |-> $onehot(sel_r), "commit without exactly one selected frame")
  `ASSERT_CLK(a_occ_bound, clk, rst_n,
    32'(occ_r) <= FRAMES, "occupancy beyond frame count")
  `ASSERT_CLK(a_commit_counts, clk, rst_n,
    cmd.commit |=> ($countones({hits_r != $past(hits_r), misses_r != $past(misses_r)}) == 1),
    "commit must bump exactly one total")

endmodule

### rtl/lru_page_cache_tracker.sv
// Fully associative page cache tracker with least-recently-used replacement.
// in_ch   : one beat per page reference (page_number, 32 bits; only the low
//           PAGE_BITS bits are compared and stored).
// out_ch  : one beat per reference: hit flag plus running hit and miss
//           totals (32 bits, wrapping).
// cfg_we / cfg_wdata : capacity write (1..16, zero acts as 1, values above
//           FRAMES act as FRAMES). Write only while the block is idle.
// Timing  : a reference is compared against every frame in parallel in the
//           cycle after it is accepted, and committed once the result register
//           is free, which loads the result register. The recency ranks are
//           updated in the commit cycle and the next lookup needs them, so a
//           new reference is accepted only while idle or in a commit cycle.
// Stall   : the result register holds a finished beat while out_ch is
//           stalled; the next reference is still accepted and looked up, and
//           it waits in the commit step until the result register drains.
// Reset   : rst_n (synchronous, active low) empties the cache, clears both
//           totals and sets capacity to 16; no clearing pass is needed.
module lru_page_cache_tracker #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  lpct_in_if.sink                       in_ch,
  lpct_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [lpct_pkg::CAP_W-1:0]    cfg_wdata
);

  lpct_pkg::lpct_cmd_t     cmd;
  lpct_pkg::lpct_status_t  st;

  lpct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  lpct_dpath #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .page_in        (in_ch.page_number),
    .cmd            (cmd),
    .st             (st),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_hit        (out_ch.hit),
    .out_hit_total  (out_ch.hit_total),
    .out_miss_total (out_ch.miss_total)
  );

endmodule
